/* rtl/core/assert_macros.svh */
// Assertion macros shared by the sorted matrix search modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define SMBS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smbs: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define SMBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smbs: next-cycle check failed");

`endif

/* rtl/core/smbs_pkg.sv */
// Package for the sorted matrix search: field widths, codes, controller states
// and the command and status structs between controller and datapath. No dependencies.
package smbs_pkg;

  localparam int CFG_W        = 5;
  localparam int CFG_IDX_W    = 1;
  localparam int POS_W        = 8;
  localparam int DATA_W       = 32;
  localparam int OUT_IDX_W    = 4;
  localparam int MAX_ROWS_DEF = 16;
  localparam int MAX_COLS_DEF = 16;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic load;
    logic start_search;
    logic probe;
    logic compare;
    logic div_start;
    logic div_step;
    logic finish_hit;
    logic finish_miss;
  } smbs_cmd_t;

  typedef struct packed {
    logic empty;
    logic hit;
    logic div_last;
  } smbs_sts_t;

endpackage

/* rtl/core/sorted_matrix_binary_search.sv */
// Loads are taken while idle and may be given back to back; they give no result.
// A search makes up to floor(log2(N)) + 1 probes over N = rows * cols entries, each probe a
// memory read, then a compare; on a hit a serial division over the flat index bits follows,
// and the result is then registered.
// One search runs at a time; busy falls in the cycle in which out_valid pulses.
// Results cannot be held off. Synchronous reset clears the controller and sets both dimensions
// to one, but not the store.
module sorted_matrix_binary_search #(
  parameter int MAX_ROWS = smbs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = smbs_pkg::MAX_COLS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [smbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [smbs_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_operation,
  input  logic [smbs_pkg::POS_W-1:0]          in_position,
  input  logic signed [smbs_pkg::DATA_W-1:0]  in_value,
  output logic                                out_valid,
  output logic                                out_found,
  output logic [smbs_pkg::OUT_IDX_W-1:0]      out_row_index,
  output logic [smbs_pkg::OUT_IDX_W-1:0]      out_col_index
);
  import smbs_pkg::*;

  smbs_cmd_t cmd;
  smbs_sts_t sts;

  smbs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy),
    .out_valid    (out_valid)
  );

  smbs_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_position   (in_position),
    .in_value      (in_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_found     (out_found),
    .out_row_index (out_row_index),
    .out_col_index (out_col_index)
  );

endmodule

/* rtl/core/smbs_datapath.sv */
// Datapath of the sorted matrix search: configuration registers, entry store,
// search bounds, probe compare, serial divider and result registers. Uses smbs_pkg.
`include "assert_macros.svh"

module smbs_datapath #(
  parameter int MAX_ROWS = smbs_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = smbs_pkg::MAX_COLS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [smbs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [smbs_pkg::CFG_W-1:0]             cfg_wdata,
  input  logic [smbs_pkg::POS_W-1:0]             in_position,
  input  logic signed [smbs_pkg::DATA_W-1:0]     in_value,
  input  smbs_pkg::smbs_cmd_t                    cmd,
  output smbs_pkg::smbs_sts_t                    sts,
  output logic                                   out_found,
  output logic [smbs_pkg::OUT_IDX_W-1:0]         out_row_index,
  output logic [smbs_pkg::OUT_IDX_W-1:0]         out_col_index
);
  import smbs_pkg::*;

  localparam int DEPTH   = MAX_ROWS * MAX_COLS;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int PROD_W  = 2 * CFG_W;
  localparam int DCNT_W  = (IDX_W > 1) ? $clog2(IDX_W) : 1;

  logic [CFG_W-1:0]         rows_cfg_r;
  logic [CFG_W-1:0]         cols_cfg_r;
  logic [CFG_W-1:0]         rows_c;
  logic [CFG_W-1:0]         cols_c;
  logic [CNT_W-1:0]         total;

  logic signed [DATA_W-1:0] entry_mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_r;
  logic signed [DATA_W-1:0] target_r;
  logic                     wr_ok;
  logic [IDX_W-1:0]         wr_addr;

  logic [CNT_W-1:0]         lo_r;
  logic [CNT_W-1:0]         hi_r;
  logic [CNT_W-1:0]         span;
  logic [CNT_W-1:0]         mid_full;
  logic [IDX_W-1:0]         mid;
  logic [IDX_W-1:0]         mid_r;

  logic [IDX_W-1:0]         dvd_r;
  logic [IDX_W-1:0]         dvd_nxt;
  logic [CFG_W-1:0]         rem_r;
  logic [CFG_W-1:0]         rem_nxt;
  logic [CFG_W:0]           div_tmp;
  logic                     div_ge;
  logic [DCNT_W-1:0]        div_cnt_r;

  logic                     found_r;
  logic [OUT_IDX_W-1:0]     row_r;
  logic [OUT_IDX_W-1:0]     col_r;

  // Configuration registers reset to one row and one column.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= CFG_W'(1);
      cols_cfg_r <= CFG_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == REG_NUM_ROWS) begin
        rows_cfg_r <= cfg_wdata;
      end else if (cfg_index == REG_NUM_COLS) begin
        cols_cfg_r <= cfg_wdata;
      end
    end
  end

  // Register values outside the supported range saturate into it.
  always_comb begin
    rows_c = rows_cfg_r;
    if (rows_cfg_r == '0) begin
      rows_c = CFG_W'(1);
    end else if (int'(rows_cfg_r) > MAX_ROWS) begin
      rows_c = CFG_W'(MAX_ROWS);
    end
    cols_c = cols_cfg_r;
    if (cols_cfg_r == '0) begin
      cols_c = CFG_W'(1);
    end else if (int'(cols_cfg_r) > MAX_COLS) begin
      cols_c = CFG_W'(MAX_COLS);
    end
  end

  assign total = CNT_W'(PROD_W'(rows_c) * PROD_W'(cols_c));

  assign wr_ok   = int'(in_position) < DEPTH;
  assign wr_addr = IDX_W'(in_position);

  always_ff @(posedge clk) begin
    if (cmd.load && wr_ok) begin
      entry_mem[wr_addr] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe) begin
      rdata_r <= entry_mem[mid];
    end
  end

  // The upper bound is exclusive, so the range is empty when lo meets hi.
  assign span     = hi_r - lo_r - CNT_W'(1);
  assign mid_full = lo_r + (span >> 1);
  assign mid      = IDX_W'(mid_full);

  always_ff @(posedge clk) begin
    if (cmd.start_search) begin
      lo_r     <= '0;
      hi_r     <= total;
      target_r <= in_value;
    end else if (cmd.compare) begin
      if (rdata_r < target_r) begin
        lo_r <= CNT_W'(mid_r) + CNT_W'(1);
      end else begin
        hi_r <= CNT_W'(mid_r);
      end
    end
    if (cmd.probe) begin
      mid_r <= mid;
    end
  end

  // Restoring division of the hit position by the column count, one bit a cycle.
  assign div_tmp = {rem_r, dvd_r[IDX_W-1]};
  assign div_ge  = div_tmp >= {1'b0, cols_c};
  assign rem_nxt = div_ge ? CFG_W'(div_tmp - {1'b0, cols_c}) : CFG_W'(div_tmp);
  assign dvd_nxt = IDX_W'({dvd_r, div_ge});

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd_r     <= mid_r;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r     <= dvd_nxt;
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r + DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_hit) begin
      found_r <= 1'b1;
      row_r   <= OUT_IDX_W'(dvd_nxt);
      col_r   <= OUT_IDX_W'(rem_nxt);
    end else if (cmd.finish_miss) begin
      found_r <= 1'b0;
      row_r   <= '0;
      col_r   <= '0;
    end
  end

  assign sts.empty    = lo_r >= hi_r;
  assign sts.hit      = rdata_r == target_r;
  assign sts.div_last = div_cnt_r == DCNT_W'(IDX_W - 1);

  assign out_found     = found_r;
  assign out_row_index = row_r;
  assign out_col_index = col_r;

  `SMBS_ASSERT_NOW(a_probe_nonempty, cmd.probe, lo_r < hi_r)
  `SMBS_ASSERT_NOW(a_div_after_hit, cmd.div_start, rdata_r == target_r)
  `SMBS_ASSERT_NEXT(a_bounds_start, cmd.start_search, lo_r == '0 && hi_r <= CNT_W'(DEPTH))

endmodule

/* rtl/core/smbs_ctrl.sv */
// Controller of the sorted matrix search: sequences loads, probe steps and the
// serial division, and drives busy and the result strobe. Uses smbs_pkg.
`include "assert_macros.svh"

module smbs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 in_operation,
  input  smbs_pkg::smbs_sts_t  sts,
  output smbs_pkg::smbs_cmd_t  cmd,
  output logic                 busy,
  output logic                 out_valid
);
  import smbs_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (in_operation == OP_SEARCH) begin
            cmd.start_search = 1'b1;
            state_nxt        = ST_PROBE;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (sts.empty) begin
          cmd.finish_miss = 1'b1;
          out_valid_nxt   = 1'b1;
          state_nxt       = ST_IDLE;
        end else begin
          cmd.probe = 1'b1;
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (sts.hit) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          cmd.compare = 1'b1;
          state_nxt   = ST_PROBE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          cmd.finish_hit = 1'b1;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;

  `SMBS_ASSERT_NOW(a_result_when_idle, out_valid_r, state_r == ST_IDLE)
  `SMBS_ASSERT_NEXT(a_single_strobe, out_valid_r, !out_valid_r)
  `SMBS_ASSERT_NEXT(a_no_result_from_idle, state_r == ST_IDLE, !out_valid_r)

endmodule
